// ----- src/lhba_pkg.sv -----
package lhba_pkg;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_ANNOTATE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] OP_JGE = 2'd0;
	localparam logic [1:0] OP_JL = 2'd1;
	localparam logic [1:0] OP_LINE = 2'd2;
	localparam logic [1:0] OP_BAD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [31:0] EMPTY_COUNT = 32'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [29:0] rev;
		logic [31:0] tgt;
	} inst_t;

	typedef struct packed {
		logic capture;
		logic write;
		logic clr1;
		logic clr0;
		logic bad;
		logic hdr_rd;
		logic hdr_chk;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic hdr_ok;
		logic step_done;
	} sts_t;

endpackage

// ----- src/lhba_ctrl.sv -----
module lhba_ctrl
	import lhba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WRITE = 3'd1;
	localparam logic [2:0] S_CLR1 = 3'd2;
	localparam logic [2:0] S_CLR0 = 3'd3;
	localparam logic [2:0] S_BAD = 3'd4;
	localparam logic [2:0] S_HDR = 3'd5;
	localparam logic [2:0] S_CHK = 3'd6;
	localparam logic [2:0] S_STEP = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					unique case (mode)
						MODE_WRITE:    state_d = S_WRITE;
						MODE_ANNOTATE: state_d = S_HDR;
						MODE_CLEAR:    state_d = S_CLR1;
						default:       state_d = S_BAD;
					endcase
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d = S_IDLE;
			end
			S_CLR1: begin
				cmd.clr1 = 1'b1;
				state_d = S_CLR0;
			end
			S_CLR0: begin
				cmd.clr0 = 1'b1;
				state_d = S_IDLE;
			end
			S_BAD: begin
				cmd.bad = 1'b1;
				state_d = S_IDLE;
			end
			S_HDR: begin
				cmd.hdr_rd = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.hdr_chk = 1'b1;
				state_d = sts.hdr_ok ? S_STEP : S_IDLE;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (sts.step_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef ASSERT_OFF
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !start) |=> (state_q == S_IDLE))
		else $error("controller left idle without a start");

	a_start_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> busy)
		else $error("accepted command did not raise busy");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && !sts.step_done) |=> (state_q == S_STEP))
		else $error("annotate run stopped before its final word");
`endif

endmodule

// ----- src/lhba_dp.sv -----
module lhba_dp
	import lhba_pkg::*;
#(
	parameter int INST_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [5:0]  address,
	input  logic [1:0]  opcode,
	input  logic [29:0] operand_rev,
	input  logic [31:0] operand_target,
	input  logic [31:0] query_rev,
	output logic        valid,
	output logic [1:0]  status,
	output logic        is_last,
	output logic [29:0] line_rev,
	output logic [31:0] line_number,
	output logic [5:0]  line_address,
	output logic [6:0]  line_count
);

	localparam int AW = $clog2(INST_DEPTH);
	localparam int CW = $clog2(INST_DEPTH + 1);

	inst_t mem [0:INST_DEPTH-1];
	inst_t rd_q;

	logic [5:0]    address_q;
	logic [1:0]    opcode_q;
	logic [29:0]   rev_q;
	logic [31:0]   tgt_q;
	logic [31:0]   qrev_q;

	logic [AW-1:0] pc_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic          bad_q;
	logic [6:0]    lines_q;

	logic          we;
	logic [AW-1:0] wa;
	inst_t         wd;
	logic [AW-1:0] ra;
	logic          in_range;

	logic          is_jmp;
	logic          ge;
	logic          taken;
	logic          end_hit;
	logic          stop_bad;
	logic [31:0]   next_pc;
	logic          next_bad;
	logic [31:0]   hdr_count;

	logic          res_fire;
	logic [1:0]    res_status;
	logic          res_last;
	logic [29:0]   res_rev;
	logic [31:0]   res_num;
	logic [5:0]    res_addr;
	logic [6:0]    res_cnt;

	logic          valid_q;
	logic [1:0]    status_q;
	logic          last_q;
	logic [29:0]   lrev_q;
	logic [31:0]   num_q;
	logic [5:0]    laddr_q;
	logic [6:0]    cnt_q;

	assign in_range = ({1'b0, address_q} < 7'(INST_DEPTH));
	assign hdr_count = rd_q.tgt;

	assign is_jmp = (rd_q.op == OP_JGE) || (rd_q.op == OP_JL);
	assign ge = (qrev_q >= {2'b00, rd_q.rev});
	assign taken = is_jmp && ((rd_q.op == OP_JGE) ? ge : !ge);
	assign end_hit = taken && (rd_q.tgt == 32'd0);
	assign stop_bad = (rem_q == '0) || bad_q || (rd_q.op == OP_BAD);
	assign next_pc = taken ? rd_q.tgt : (32'(pc_q) + 32'd1);
	assign next_bad = (next_pc >= 32'(count_q));

	assign sts.hdr_ok = (hdr_count != 32'd0) && (hdr_count <= 32'(INST_DEPTH));
	assign sts.step_done = stop_bad || end_hit;

	always_comb begin
		we = 1'b0;
		wa = address_q[AW-1:0];
		wd = '{op: opcode_q, rev: rev_q, tgt: tgt_q};
		if (cmd.write) begin
			we = in_range;
		end else if (cmd.clr1) begin
			we = 1'b1;
			wa = AW'(1);
			wd = '{op: OP_JGE, rev: 30'd0, tgt: 32'd0};
		end else if (cmd.clr0) begin
			we = 1'b1;
			wa = '0;
			wd = '{op: OP_JGE, rev: 30'd0, tgt: EMPTY_COUNT};
		end
	end

	always_comb begin
		ra = '0;
		if (cmd.hdr_rd) begin
			ra = '0;
		end else if (cmd.hdr_chk) begin
			ra = AW'(1);
		end else if (cmd.step && !next_bad) begin
			ra = next_pc[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			address_q <= address;
			opcode_q <= opcode;
			rev_q <= operand_rev;
			tgt_q <= operand_target;
			qrev_q <= query_rev;
		end
		if (cmd.hdr_chk) begin
			count_q <= hdr_count[CW-1:0];
			rem_q <= hdr_count[CW-1:0] - CW'(1);
			pc_q <= AW'(1);
			bad_q <= 1'b0;
			lines_q <= 7'd0;
		end else if (cmd.step) begin
			pc_q <= next_pc[AW-1:0];
			bad_q <= next_bad;
			rem_q <= rem_q - CW'(1);
			if (!stop_bad && rd_q.op == OP_LINE) begin
				lines_q <= lines_q + 7'd1;
			end
		end
	end

	always_comb begin
		res_fire = 1'b0;
		res_status = ST_OK;
		res_last = 1'b1;
		res_rev = '0;
		res_num = '0;
		res_addr = '0;
		res_cnt = '0;
		if (cmd.write) begin
			res_fire = 1'b1;
			res_status = in_range ? ST_OK : ST_RANGE;
		end else if (cmd.clr0) begin
			res_fire = 1'b1;
		end else if (cmd.bad) begin
			res_fire = 1'b1;
			res_status = ST_ILLEGAL;
		end else if (cmd.hdr_chk) begin
			res_fire = !sts.hdr_ok;
			res_status = ST_ILLEGAL;
		end else if (cmd.step) begin
			res_cnt = lines_q;
			if (stop_bad) begin
				res_fire = 1'b1;
				res_status = ST_ILLEGAL;
			end else if (end_hit) begin
				res_fire = 1'b1;
				res_addr = 6'(pc_q);
			end else if (rd_q.op == OP_LINE) begin
				res_fire = 1'b1;
				res_last = 1'b0;
				res_rev = rd_q.rev;
				res_num = rd_q.tgt;
				res_addr = 6'(pc_q);
				res_cnt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q <= res_status;
			last_q <= res_last;
			lrev_q <= res_rev;
			num_q <= res_num;
			laddr_q <= res_addr;
			cnt_q <= res_cnt;
		end
	end

	assign valid = valid_q;
	assign status = status_q;
	assign is_last = last_q;
	assign line_rev = lrev_q;
	assign line_number = num_q;
	assign line_address = laddr_q;
	assign line_count = cnt_q;

`ifndef ASSERT_OFF
	a_hdr_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hdr_chk && !sts.hdr_ok) |=> (valid && is_last && status == ST_ILLEGAL))
		else $error("bad header count gave no illegal-data result");

	a_line_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !is_last) |-> (status == ST_OK && line_count == 7'd0))
		else $error("line word carries a status or a count");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.step_done) |=> (valid && is_last))
		else $error("annotate run ended without a final word");
`endif

endmodule

// ----- src/line_history_bytecode_annotator.sv -----
// Channel  | Handshake          | Ports
// ---------+--------------------+------------------------------------------------------
// command  | start && !busy     | mode, address, opcode, operand_rev, operand_target,
//          |                    | query_rev
// result   | valid (one cycle)  | status, is_last, line_rev, line_number, line_address,
//          |                    | line_count
//
// A write, clear or unused-mode command gives its single word after acceptance. An
// annotate command reads the header, then executes one instruction per cycle; the
// loop is one memory read per step, with the next address taken from the word just
// read. Reset clears the controller and the result strobe; the instruction store is
// undefined until written. The receiver cannot stall, and busy stays high until the
// final word of a command is in the result register.
module line_history_bytecode_annotator
	import lhba_pkg::*;
#(
	parameter int INST_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [5:0]  address,
	input  logic [1:0]  opcode,
	input  logic [29:0] operand_rev,
	input  logic [31:0] operand_target,
	input  logic [31:0] query_rev,
	output logic        valid,
	output logic [1:0]  status,
	output logic        is_last,
	output logic [29:0] line_rev,
	output logic [31:0] line_number,
	output logic [5:0]  line_address,
	output logic [6:0]  line_count
);

	cmd_t cmd;
	sts_t sts;

	lhba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lhba_dp #(
		.INST_DEPTH (INST_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.address        (address),
		.opcode         (opcode),
		.operand_rev    (operand_rev),
		.operand_target (operand_target),
		.query_rev      (query_rev),
		.valid          (valid),
		.status         (status),
		.is_last        (is_last),
		.line_rev       (line_rev),
		.line_number    (line_number),
		.line_address   (line_address),
		.line_count     (line_count)
	);

endmodule

// ----- tb/annotation_checker.sv -----
`timescale 1ns / 100ps

module annotation_checker
	import lhba_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [5:0]  address,
	input  logic [1:0]  opcode,
	input  logic [29:0] operand_rev,
	input  logic [31:0] operand_target,
	input  logic [31:0] query_rev,
	input  logic        valid,
	input  logic [1:0]  status,
	input  logic        is_last,
	input  logic [29:0] line_rev,
	input  logic [31:0] line_number,
	input  logic [5:0]  line_address,
	input  logic [6:0]  line_count,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0]  status;
		logic        is_last;
		logic [29:0] rev;
		logic [31:0] number;
		logic [5:0]  slot;
		logic [6:0]  count;
	} line_word_t;

	inst_t      program_copy [DEPTH];
	line_word_t pending_words [$];

	function automatic line_word_t word_of(logic [1:0] st, logic last, logic [29:0] rev,
			logic [31:0] number, logic [5:0] slot, logic [6:0] count);
		line_word_t w;
		w.status = st;
		w.is_last = last;
		w.rev = rev;
		w.number = number;
		w.slot = slot;
		w.count = count;
		return w;
	endfunction

	// Walks the stored program for one query revision and queues the line words
	// it emits, followed by the closing word.
	task automatic annotate_run(input logic [31:0] query);
		logic [31:0] count;
		logic [31:0] pc;
		logic [31:0] next_pc;
		logic [5:0]  end_slot;
		logic        broken;
		logic        taken;
		int          steps;
		int          lines;
		inst_t       w;
		count = program_copy[0].tgt;
		if (count == 0 || count > DEPTH) begin
			pending_words.push_back(word_of(ST_ILLEGAL, 1'b1, '0, '0, '0, '0));
			return;
		end
		steps = count;
		pc = 32'd1;
		lines = 0;
		end_slot = '0;
		broken = 1'b0;
		while (pc != 0 && !broken) begin
			steps--;
			if (steps == 0)
				break;
			if (pc >= count) begin
				broken = 1'b1;
			end else begin
				w = program_copy[pc[5:0]];
				next_pc = pc + 1;
				if (w.op == OP_LINE) begin
					pending_words.push_back(word_of(ST_OK, 1'b0, w.rev, w.tgt, pc[5:0], '0));
					lines++;
				end else if (w.op == OP_BAD) begin
					broken = 1'b1;
				end else begin
					if (w.op == OP_JGE)
						taken = query >= {2'b00, w.rev};
					else
						taken = query < {2'b00, w.rev};
					if (taken) begin
						next_pc = w.tgt;
						if (w.tgt == 0)
							end_slot = pc[5:0];
					end
				end
				pc = next_pc;
			end
		end
		if (broken || end_slot == 0)
			pending_words.push_back(word_of(ST_ILLEGAL, 1'b1, '0, '0, '0, lines[6:0]));
		else
			pending_words.push_back(word_of(ST_OK, 1'b1, '0, '0, end_slot, lines[6:0]));
	endtask

	always @(posedge clk) begin
		line_word_t got;
		line_word_t wanted;
		if (arst_n) begin
			if (valid) begin
				got = word_of(status, is_last, line_rev, line_number, line_address, line_count);
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: st=%0d last=%0d rev=%h line=%h slot=%0d n=%0d",
							got.status, got.is_last, got.rev, got.number, got.slot, got.count);
				end else begin
					wanted = pending_words.pop_front();
					if (got !== wanted) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("word mismatch: want st=%0d last=%0d rev=%h line=%h slot=%0d n=%0d",
								wanted.status, wanted.is_last, wanted.rev, wanted.number,
								wanted.slot, wanted.count);
							$display("                got st=%0d last=%0d rev=%h line=%h slot=%0d n=%0d",
								got.status, got.is_last, got.rev, got.number, got.slot, got.count);
						end
					end
				end
			end
			if (start && !busy) begin
				case (mode)
					MODE_WRITE: begin
						if (int'(address) < DEPTH) begin
							program_copy[address] = '{opcode, operand_rev, operand_target};
							pending_words.push_back(word_of(ST_OK, 1'b1, '0, '0, '0, '0));
						end else begin
							pending_words.push_back(word_of(ST_RANGE, 1'b1, '0, '0, '0, '0));
						end
					end
					MODE_CLEAR: begin
						program_copy[1] = '{OP_JGE, 30'd0, 32'd0};
						program_copy[0] = '{OP_JGE, 30'd0, EMPTY_COUNT};
						pending_words.push_back(word_of(ST_OK, 1'b1, '0, '0, '0, '0));
					end
					MODE_ANNOTATE: begin
						annotate_run(query_rev);
					end
					default: begin
						pending_words.push_back(word_of(ST_ILLEGAL, 1'b1, '0, '0, '0, '0));
					end
				endcase
			end
			outstanding = pending_words.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import lhba_pkg::*;

	localparam int DEPTH = 64;
	localparam int ITEM_TARGET = 270;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_OP,
		FLAW_FAR_JUMP,
		FLAW_NO_END,
		FLAW_LOOP
	} flaw_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [5:0]  address;
	logic [1:0]  opcode;
	logic [29:0] operand_rev;
	logic [31:0] operand_target;
	logic [31:0] query_rev;
	logic        valid;
	logic [1:0]  status;
	logic        is_last;
	logic [29:0] line_rev;
	logic [31:0] line_number;
	logic [5:0]  line_address;
	logic [6:0]  line_count;

	int          mismatches;
	int          outstanding;
	int          cycle_count = 0;
	int          sent;
	int          calm_left;
	bit          slot_written [DEPTH];
	logic [31:0] header_count;

	line_history_bytecode_annotator #(
		.INST_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.address(address),
		.opcode(opcode),
		.operand_rev(operand_rev),
		.operand_target(operand_target),
		.query_rev(query_rev),
		.valid(valid),
		.status(status),
		.is_last(is_last),
		.line_rev(line_rev),
		.line_number(line_number),
		.line_address(line_address),
		.line_count(line_count)
	);

	annotation_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.address(address),
		.opcode(opcode),
		.operand_rev(operand_rev),
		.operand_target(operand_target),
		.query_rev(query_rev),
		.valid(valid),
		.status(status),
		.is_last(is_last),
		.line_rev(line_rev),
		.line_number(line_number),
		.line_address(line_address),
		.line_count(line_count),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic issue(input logic [1:0] m, input logic [5:0] slot, input logic [1:0] op,
			input logic [29:0] rev, input logic [31:0] tgt, input logic [31:0] query);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 19) == 0)
				calm_left = $urandom_range(5, 25);
		end
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode <= m;
		address <= slot;
		opcode <= op;
		operand_rev <= rev;
		operand_target <= tgt;
		query_rev <= query;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sent++;
		if (m == MODE_WRITE) begin
			slot_written[slot] = 1'b1;
			if (slot == 0)
				header_count = tgt;
		end else if (m == MODE_CLEAR) begin
			slot_written[0] = 1'b1;
			slot_written[1] = 1'b1;
			header_count = EMPTY_COUNT;
		end
	endtask

	task automatic put_word(input logic [5:0] slot, input logic [1:0] op, input logic [29:0] rev,
			input logic [31:0] tgt);
		issue(MODE_WRITE, slot, op, rev, tgt, $urandom);
	endtask

	task automatic annotate(input logic [31:0] query);
		issue(MODE_ANNOTATE, 6'($urandom), 2'($urandom), 30'($urandom), $urandom, query);
	endtask

	task automatic clear_log();
		issue(MODE_CLEAR, 6'($urandom), 2'($urandom), 30'($urandom), $urandom, $urandom);
	endtask

	function automatic logic [31:0] pick_query();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'hffffffff;
		if (roll < 3)
			return $urandom;
		return $urandom_range(0, 21);
	endfunction

	// A run never uses a slot that has not been written.
	function automatic bit annotate_is_safe();
		if (!slot_written[0])
			return 1'b0;
		if (header_count == 0 || header_count > DEPTH)
			return 1'b1;
		for (int s = 1; s < header_count; s++)
			if (!slot_written[s])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic load_program(input int n, input flaw_t flaw);
		inst_t prog [DEPTH];
		int    s;
		int    pick;
		for (int i = 1; i < n; i++) begin
			pick = $urandom_range(0, 9);
			if (i == n - 1)
				pick = (flaw == FLAW_NO_END) ? 0 : 10;
			prog[i].rev = 30'($urandom_range(0, 20));
			if (pick < 5) begin
				prog[i].op = OP_LINE;
				prog[i].rev = 30'($urandom);
				prog[i].tgt = $urandom;
			end else if (pick < 8) begin
				prog[i].op = pick[0] ? OP_JL : OP_JGE;
				prog[i].tgt = $urandom_range(i + 1, n - 1);
			end else if (pick < 10) begin
				prog[i].op = pick[0] ? OP_JL : OP_JGE;
				prog[i].tgt = 32'd0;
			end else begin
				prog[i] = '{OP_JGE, 30'd0, 32'd0};
			end
		end
		s = $urandom_range(1, n - 1);
		case (flaw)
			FLAW_BAD_OP: prog[s].op = OP_BAD;
			FLAW_FAR_JUMP: begin
				prog[s].op = OP_JGE;
				prog[s].rev = 30'd0;
				if ($urandom_range(0, 3) == 0)
					prog[s].tgt = 32'hffffffff;
				else
					prog[s].tgt = n + $urandom_range(0, 100);
			end
			FLAW_LOOP: prog[s] = '{OP_JL, 30'h3fffffff, $urandom_range(1, s)};
			default: ;
		endcase
		for (int i = 1; i < n; i++)
			put_word(6'(i), prog[i].op, prog[i].rev, prog[i].tgt);
		put_word(6'd0, 2'($urandom), 30'($urandom), n);
	endtask

	initial begin
		int    round;
		int    choice;
		int    n;
		flaw_t flaw;
		logic [5:0] slot;
		logic [31:0] tgt;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_WRITE;
		address = '0;
		opcode = OP_JGE;
		operand_rev = '0;
		operand_target = '0;
		query_rev = '0;
		sent = 0;
		calm_left = 0;
		header_count = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		clear_log();
		annotate(32'd0);
		annotate(32'hffffffff);
		issue(MODE_UNUSED, 6'($urandom), 2'($urandom), 30'($urandom), $urandom, $urandom);
		put_word(6'd0, OP_LINE, 30'h3fffffff, 32'd0);
		annotate(32'd0);
		put_word(6'd0, OP_JL, 30'd0, DEPTH + 1);
		annotate(32'd7);
		put_word(6'd0, OP_BAD, 30'd5, 32'hffffffff);
		annotate(32'd7);
		put_word(6'd0, OP_JGE, 30'd0, 32'd1);
		annotate(32'd7);
		put_word(6'd1, OP_LINE, 30'h3fffffff, 32'hffffffff);
		put_word(6'd2, OP_JL, 30'd5, 32'd4);
		put_word(6'd3, OP_LINE, 30'd0, 32'd0);
		put_word(6'd4, OP_JGE, 30'd0, 32'd0);
		put_word(6'd0, OP_JGE, 30'd9, 32'd5);
		annotate(32'd4);
		annotate(32'd5);
		put_word(6'd3, OP_BAD, 30'd1, 32'd1);
		annotate(32'd5);
		put_word(6'd2, OP_JL, 30'd5, 32'd40);
		annotate(32'd0);
		put_word(6'd63, OP_LINE, 30'h2aaaaaaa, 32'h55555555);

		round = 0;
		while (sent < ITEM_TARGET) begin
			choice = $urandom_range(0, 9);
			if (choice < 7) begin
				if (round == 0 || $urandom_range(0, 11) == 0)
					n = DEPTH;
				else
					n = $urandom_range(2, 12);
				flaw = FLAW_NONE;
				if ($urandom_range(0, 3) == 0)
					flaw = flaw_t'($urandom_range(1, 4));
				load_program(n, flaw);
				repeat ($urandom_range(1, 4)) annotate(pick_query());
			end else if (choice == 7) begin
				clear_log();
				annotate(pick_query());
			end else if (choice == 8) begin
				slot = 6'($urandom_range(0, DEPTH - 1));
				tgt = $urandom;
				if (slot == 0 && $urandom_range(0, 1) == 1)
					tgt = $urandom_range(0, 70);
				put_word(slot, 2'($urandom), 30'($urandom), tgt);
				if (annotate_is_safe())
					annotate(pick_query());
			end else begin
				issue(MODE_UNUSED, 6'($urandom), 2'($urandom), 30'($urandom), $urandom,
					$urandom);
			end
			round++;
		end

		@(negedge clk);
		start <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
